>>> design/des_pkg.sv
// Package with DES permutation tables, S-boxes and round helper functions.
package des_pkg;

	localparam int DesRounds = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 64;
	localparam logic [CfgIdxW-1:0] CFG_KEY = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_DECRYPT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ROUNDS = 2'd2;

	typedef logic [47:0] rkey_t;

	localparam logic [7:0] TAB_IP [64] = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam logic [7:0] TAB_FP [64] = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam logic [7:0] TAB_E [48] = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
	localparam logic [7:0] TAB_P [32] = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam logic [7:0] TAB_PC1 [56] = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
		60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
		61,53,45,37,29,21,13,5,28,20,12,4};
	localparam logic [7:0] TAB_PC2 [48] = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
	localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
	localparam logic [3:0] TAB_SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic logic [63:0] perm_ip(input logic [63:0] v);
		logic [63:0] r;
		for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(TAB_IP[k])];
		return r;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] v);
		logic [63:0] r;
		for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(TAB_FP[k])];
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] v);
		logic [55:0] r;
		for (int k = 0; k < 56; k++) r[55-k] = v[64-int'(TAB_PC1[k])];
		return r;
	endfunction

	function automatic rkey_t perm_pc2(input logic [55:0] v);
		rkey_t r;
		for (int k = 0; k < 48; k++) r[47-k] = v[56-int'(TAB_PC2[k])];
		return r;
	endfunction

	function automatic logic [27:0] rot28(input logic [27:0] c, input logic [1:0] s);
		return (s == 2'd2) ? {c[25:0], c[27:26]} : {c[26:0], c[27]};
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input rkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [5:0] six;
		logic [31:0] p;
		for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TAB_E[i])];
		x = x ^ k;
		for (int j = 0; j < 8; j++) begin
			six = x[47-6*j -: 6];
			s[31-4*j -: 4] = TAB_SBOX[j][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TAB_P[i])];
		return p;
	endfunction

endpackage

>>> design/des_block_cipher_unit.sv
// Each block passes the initial-permutation register, then the round registers in order.
// Throughput: one block per cycle through an unrolled round pipeline while the output is not stalled.
// Round keys follow the key register through fixed wiring of the key schedule.
// Reset (arst_n low) clears valid flags and sets key 0, encrypt, 16 rounds.
// A stalled output holds the whole pipeline and the input.
module des_block_cipher_unit #(
	parameter int MAX_ROUNDS = des_pkg::DesRounds
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [des_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [des_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [63:0]                  data_block,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [63:0]                  result_block
);
	import des_pkg::*;

	logic [63:0] key_q;
	logic        decrypt_q;
	logic [4:0]  rounds_q;
	rkey_t       rk [DesRounds];
	logic [4:0]  nr;

	logic [31:0] l_s [MAX_ROUNDS+1];
	logic [31:0] r_s [MAX_ROUNDS+1];
	logic [4:0]  n_s [MAX_ROUNDS+1];
	logic        v_s [MAX_ROUNDS+1];
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			decrypt_q <= 1'b0;
			rounds_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY: key_q <= cfg_data;
				CFG_DECRYPT: decrypt_q <= cfg_data[0];
				CFG_ROUNDS: rounds_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Key schedule, recomputed from the key register; the user must change config only while idle (not enforced here).
	always_comb begin
		logic [55:0] cd;
		logic [27:0] c, d;
		cd = perm_pc1(key_q);
		c = cd[55:28];
		d = cd[27:0];
		for (int i = 0; i < DesRounds; i++) begin
			c = rot28(c, TAB_ROT[i]);
			d = rot28(d, TAB_ROT[i]);
			rk[i] = perm_pc2({c, d});
		end
	end

	always_comb begin
		if (rounds_q == 5'd0) nr = 5'd1;
		else if (rounds_q > 5'(MAX_ROUNDS)) nr = 5'(MAX_ROUNDS);
		else nr = rounds_q;
	end

	assign adv = !v_s[MAX_ROUNDS] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_ROUNDS; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= MAX_ROUNDS; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			{l_s[0], r_s[0]} <= perm_ip(data_block);
			n_s[0] <= nr;
			for (int i = 1; i <= MAX_ROUNDS; i++) begin
				n_s[i] <= n_s[i-1];
				if (5'(i) <= n_s[i-1]) begin
					l_s[i] <= r_s[i-1];
					r_s[i] <= l_s[i-1] ^ feistel(r_s[i-1],
						rk[4'(decrypt_q ? (DesRounds - i) : (i - 1))]);
				end else begin
					l_s[i] <= l_s[i-1];
					r_s[i] <= r_s[i-1];
				end
			end
		end
	end

	assign out_valid = v_s[MAX_ROUNDS];
	assign result_block = perm_fp({r_s[MAX_ROUNDS], l_s[MAX_ROUNDS]});

endmodule
